// ----- design/scsp_pkg.sv -----
package scsp_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam int          FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ENTRY = 2'd2;
    localparam logic [1:0] KIND_FILE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_SIGNATURE = 3'd2;
    localparam logic [2:0] ST_CHECKSUM  = 3'd3;
    localparam logic [2:0] ST_VERSION   = 3'd4;
    localparam logic [2:0] ST_ENTRY     = 3'd5;
    localparam logic [2:0] ST_VALUE     = 3'd6;
    localparam logic [2:0] ST_TYPE      = 3'd7;

    localparam logic [2:0] REG_XOR_KEY  = 3'd0;
    localparam logic [2:0] REG_VERSION  = 3'd1;
    localparam logic [2:0] REG_BOOL     = 3'd2;
    localparam logic [2:0] REG_NUMBER   = 3'd3;
    localparam logic [2:0] REG_STRING   = 3'd4;

    typedef enum logic [11:0] {
        PH_HDR  = 12'b0000_0000_0001,
        PH_VER  = 12'b0000_0000_0010,
        PH_CNT  = 12'b0000_0000_0100,
        PH_KLEN = 12'b0000_0000_1000,
        PH_KEY  = 12'b0000_0001_0000,
        PH_TYPE = 12'b0000_0010_0000,
        PH_BOOL = 12'b0000_0100_0000,
        PH_NUM  = 12'b0000_1000_0000,
        PH_SLEN = 12'b0001_0000_0000,
        PH_STR  = 12'b0010_0000_0000,
        PH_DONE = 12'b0100_0000_0000,
        PH_STOP = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] type_word;
        logic [31:0] number;
        logic        bool_bit;
        logic [2:0]  status;
        logic        last;
    } token_t;

    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } token_pair_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        case (p)
            3'd0: r = 8'h46;
            3'd1: r = 8'h4C;
            3'd2: r = 8'h58;
            3'd3: r = 8'h53;
            3'd4: r = 8'h41;
            3'd5: r = 8'h56;
            3'd6: r = 8'h45;
            default: r = 8'h31;
        endcase
        return r;
    endfunction

    // x * 16777619 mod 2^32, prime = 2^24 + 0x193
    function automatic logic [31:0] fnv_mul(input logic [31:0] x);
        return {x[7:0], 24'd0} + (x * 32'h0000_0193);
    endfunction

endpackage

// ----- design/scsp_parser.sv -----
module scsp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 accept,
    input  logic [7:0]           file_byte,
    input  logic                 final_byte,
    output scsp_pkg::token_pair_t res
);

    logic [7:0]       xor_key_reg;
    logic [31:0]      version_reg, bool_code_reg, num_code_reg, str_code_reg;

    scsp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       hpos_reg, hpos_next;
    logic [31:0]      sum_reg, sum_next;
    logic [31:0]      hash_reg, hash_next;
    logic [31:0]      asm_reg, asm_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      ecnt_reg, ecnt_next;
    logic [31:0]      sleft_reg, sleft_next;
    logic [31:0]      type_reg, type_next;
    logic [2:0]       ferr_reg, ferr_next;

    logic [7:0]       d;
    logic [31:0]      w;
    logic             word_done, word_phase, ended, end_bool;
    logic [31:0]      sleft_dec, left_dec;
    logic [2:0]       st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg   <= 8'h5A;
            version_reg   <= 32'd1;
            bool_code_reg <= 32'd0;
            num_code_reg  <= 32'd1;
            str_code_reg  <= 32'd2;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                scsp_pkg::REG_XOR_KEY: xor_key_reg   <= cfg_data[7:0];
                scsp_pkg::REG_VERSION: version_reg   <= cfg_data;
                scsp_pkg::REG_BOOL:    bool_code_reg <= cfg_data;
                scsp_pkg::REG_NUMBER:  num_code_reg  <= cfg_data;
                scsp_pkg::REG_STRING:  str_code_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= scsp_pkg::PH_HDR;
            hpos_reg  <= 4'd0;
            sum_reg   <= 32'd0;
            hash_reg  <= scsp_pkg::FNV_BASIS;
            asm_reg   <= 32'd0;
            cnt_reg   <= 2'd0;
            left_reg  <= 32'd0;
            ecnt_reg  <= 32'd0;
            sleft_reg <= 32'd0;
            type_reg  <= 32'd0;
            ferr_reg  <= scsp_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            sum_reg   <= sum_next;
            hash_reg  <= hash_next;
            asm_reg   <= asm_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            ecnt_reg  <= ecnt_next;
            sleft_reg <= sleft_next;
            type_reg  <= type_next;
            ferr_reg  <= ferr_next;
        end
    end

    assign d         = file_byte ^ xor_key_reg;
    assign w         = {d, asm_reg[23:0]};
    assign word_done = (cnt_reg == 2'd3);
    assign sleft_dec = sleft_reg - 32'd1;
    assign left_dec  = left_reg - 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        sum_next   = sum_reg;
        hash_next  = hash_reg;
        asm_next   = asm_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        ecnt_next  = ecnt_reg;
        sleft_next = sleft_reg;
        type_next  = type_reg;
        ferr_next  = ferr_reg;
        ended      = 1'b0;
        end_bool   = 1'b0;
        word_phase = 1'b0;
        st         = scsp_pkg::ST_OK;
        res        = '0;

        if (accept)
        begin
            if (phase_reg == scsp_pkg::PH_HDR)
            begin
                if (!hpos_reg[3])
                begin
                    if (file_byte != scsp_pkg::sig_byte(hpos_reg[2:0]) &&
                        ferr_reg == scsp_pkg::ST_OK)
                        ferr_next = scsp_pkg::ST_SIGNATURE;
                end
                else
                    sum_next = sum_reg | ({24'd0, file_byte} << {hpos_reg[1:0], 3'b000});
                hpos_next = hpos_reg + 4'd1;
                if (hpos_next >= 4'd12)
                    phase_next = (ferr_next == scsp_pkg::ST_SIGNATURE) ?
                                 scsp_pkg::PH_STOP : scsp_pkg::PH_VER;
            end
            else
            begin
                hash_next = scsp_pkg::fnv_mul(hash_reg ^ {24'd0, file_byte});
                word_phase = (phase_reg == scsp_pkg::PH_VER)  ||
                             (phase_reg == scsp_pkg::PH_CNT)  ||
                             (phase_reg == scsp_pkg::PH_KLEN) ||
                             (phase_reg == scsp_pkg::PH_TYPE) ||
                             (phase_reg == scsp_pkg::PH_BOOL) ||
                             (phase_reg == scsp_pkg::PH_SLEN);
                if (word_phase)
                begin
                    if (word_done)
                    begin
                        asm_next = 32'd0;
                        cnt_next = 2'd0;
                    end
                    else
                    begin
                        asm_next = asm_reg | ({24'd0, d} << {cnt_reg, 3'b000});
                        cnt_next = cnt_reg + 2'd1;
                    end
                end

                unique case (phase_reg) inside
                    scsp_pkg::PH_VER:
                        if (word_done)
                        begin
                            if (w != version_reg)
                            begin
                                ferr_next  = scsp_pkg::ST_VERSION;
                                phase_next = scsp_pkg::PH_STOP;
                            end
                            else
                                phase_next = scsp_pkg::PH_CNT;
                        end
                    scsp_pkg::PH_CNT:
                        if (word_done)
                        begin
                            left_next  = w;
                            phase_next = (w == 32'd0) ? scsp_pkg::PH_DONE : scsp_pkg::PH_KLEN;
                        end
                    scsp_pkg::PH_KLEN:
                        if (word_done)
                        begin
                            sleft_next = w;
                            phase_next = (w == 32'd0) ? scsp_pkg::PH_TYPE : scsp_pkg::PH_KEY;
                        end
                    scsp_pkg::PH_KEY:
                    begin
                        res.v0        = 1'b1;
                        res.t0.kind   = scsp_pkg::KIND_KEY;
                        res.t0.data   = d;
                        res.t0.number = ecnt_reg;
                        sleft_next    = sleft_dec;
                        if (sleft_dec == 32'd0)
                            phase_next = scsp_pkg::PH_TYPE;
                    end
                    scsp_pkg::PH_TYPE:
                        if (word_done)
                        begin
                            type_next = w;
                            if (w == bool_code_reg)
                                phase_next = scsp_pkg::PH_BOOL;
                            else if (w == num_code_reg)
                            begin
                                phase_next = scsp_pkg::PH_NUM;
                                sleft_next = 32'd8;
                            end
                            else if (w == str_code_reg)
                                phase_next = scsp_pkg::PH_SLEN;
                            else
                            begin
                                ferr_next  = scsp_pkg::ST_TYPE;
                                phase_next = scsp_pkg::PH_STOP;
                            end
                        end
                    scsp_pkg::PH_BOOL:
                        if (word_done)
                        begin
                            ended    = 1'b1;
                            end_bool = (w != 32'd0);
                        end
                    scsp_pkg::PH_SLEN:
                        if (word_done)
                        begin
                            sleft_next = w;
                            if (w == 32'd0)
                                ended = 1'b1;
                            else
                                phase_next = scsp_pkg::PH_STR;
                        end
                    scsp_pkg::PH_NUM, scsp_pkg::PH_STR:
                    begin
                        res.v0        = 1'b1;
                        res.t0.kind   = scsp_pkg::KIND_VALUE;
                        res.t0.data   = d;
                        res.t0.number = ecnt_reg;
                        sleft_next    = sleft_dec;
                        if (sleft_dec == 32'd0)
                            ended = 1'b1;
                    end
                    default: ;
                endcase

                if (ended)
                begin
                    ecnt_next  = ecnt_reg + 32'd1;
                    left_next  = left_dec;
                    phase_next = (left_dec == 32'd0) ? scsp_pkg::PH_DONE : scsp_pkg::PH_KLEN;
                    res.t1.kind      = scsp_pkg::KIND_ENTRY;
                    res.t1.type_word = type_reg;
                    res.t1.number    = ecnt_reg;
                    res.t1.bool_bit  = end_bool;
                    res.v1           = !final_byte;
                end
            end

            if (final_byte)
            begin
                if (hpos_next < 4'd12)
                    st = scsp_pkg::ST_SHORT;
                else if (ferr_next == scsp_pkg::ST_SIGNATURE)
                    st = scsp_pkg::ST_SIGNATURE;
                else if (hash_next != sum_next)
                    st = scsp_pkg::ST_CHECKSUM;
                else if (ferr_next != scsp_pkg::ST_OK)
                    st = ferr_next;
                else if (phase_next == scsp_pkg::PH_VER || phase_next == scsp_pkg::PH_CNT)
                    st = scsp_pkg::ST_VERSION;
                else if (phase_next == scsp_pkg::PH_KLEN || phase_next == scsp_pkg::PH_KEY ||
                         phase_next == scsp_pkg::PH_TYPE)
                    st = scsp_pkg::ST_ENTRY;
                else if (phase_next == scsp_pkg::PH_BOOL || phase_next == scsp_pkg::PH_NUM ||
                         phase_next == scsp_pkg::PH_SLEN || phase_next == scsp_pkg::PH_STR)
                    st = scsp_pkg::ST_VALUE;
                else
                    st = scsp_pkg::ST_OK;

                res.v1           = 1'b1;
                res.t1.kind      = scsp_pkg::KIND_FILE;
                res.t1.data      = 8'd0;
                res.t1.type_word = ended ? type_reg : 32'd0;
                res.t1.number    = ecnt_next;
                res.t1.bool_bit  = ended & end_bool;
                res.t1.status    = st;
                res.t1.last      = 1'b1;

                phase_next = scsp_pkg::PH_HDR;
                hpos_next  = 4'd0;
                sum_next   = 32'd0;
                hash_next  = scsp_pkg::FNV_BASIS;
                asm_next   = 32'd0;
                cnt_next   = 2'd0;
                left_next  = 32'd0;
                ecnt_next  = 32'd0;
                sleft_next = 32'd0;
                type_next  = 32'd0;
                ferr_next  = scsp_pkg::ST_OK;
            end
        end
    end

`ifndef SYNTHESIS
    a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != scsp_pkg::PH_HDR) |-> (hpos_reg == 4'd12))
        else $error("header position off while parsing payload");
    a_sig_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (ferr_reg == scsp_pkg::ST_SIGNATURE && phase_reg != scsp_pkg::PH_HDR)
        |-> (phase_reg == scsp_pkg::PH_STOP))
        else $error("parsing after bad signature");
    a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (ferr_reg != scsp_pkg::ST_OK && phase_reg != scsp_pkg::PH_HDR)
        |-> (phase_reg == scsp_pkg::PH_STOP))
        else $error("error recorded but parse not stopped");
`endif

endmodule

// ----- design/scsp_out_fifo.sv -----
module scsp_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scsp_pkg::token_pair_t res,
    output logic                  room,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output scsp_pkg::token_t      m_token
);

    scsp_pkg::token_t mem [scsp_pkg::FIFO_DEPTH];
    logic [1:0]       wr_reg, rd_reg;
    logic [2:0]       cnt_reg;
    logic [1:0]       n_push;
    logic             pop;
    scsp_pkg::token_t first;

    assign n_push   = {1'b0, res.v0} + {1'b0, res.v1};
    assign first    = res.v0 ? res.t0 : res.t1;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop      = m_tvalid & m_tready;
    assign room     = (cnt_reg <= 3'd2);
    assign m_token  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_reg] <= first;
        if (n_push == 2'd2)
            mem[wr_reg + 2'd1] <= res.t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_reg + n_push;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, n_push} - {2'b00, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("output queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> room)
        else $error("push without room");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (cnt_reg == $past(cnt_reg) + {1'b0, $past(n_push)}
                          - {2'b00, $past(pop)}))
        else $error("queue count mismatch");
`endif

endmodule

// ----- design/save_container_stream_parser.sv -----
// Save container stream parser.
// Input stream: one raw container byte per item in s_tdata[7:0]; s_tlast marks
// the final byte of a container. Output stream: tokens; m_tuser is the kind
// (key byte, value byte, entry end, file end), m_tlast marks the file end item,
// which carries the status. A nonzero status voids earlier tokens of that file.
// Configuration: cfg_wen/cfg_index/cfg_data write one register per cycle
// (0 xor key, 1 version, 2 bool code, 3 number code, 4 string code); write
// only while the block is idle.
// Tokens of an accepted byte are registered in the 4-entry output queue, which
// accepts input only with two free slots. Throughput: one byte per cycle while
// each byte gives at most one token and the receiver is ready; a byte that gives
// two tokens sends them in turn through the single output port.
// Reset: registers return to defaults and the parser waits for a signature.
// When the receiver stalls, tokens collect in the queue and s_tready drops
// once fewer than two slots remain; no item is lost.
module save_container_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_byte, entry_type_word, entry_number,
                                   // bool_result, file_status, zero pad
    output logic [1:0]  m_tuser,   // [1:0] token_kind
    output logic        m_tlast
);

    scsp_pkg::token_pair_t res;
    scsp_pkg::token_t      tok;
    logic                  room;

    assign s_tready = room;

    scsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (s_tvalid & room),
        .file_byte  (s_tdata),
        .final_byte (s_tlast),
        .res        (res)
    );

    scsp_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_token  (tok)
    );

    assign m_tdata = {4'd0, tok.status, tok.bool_bit, tok.number, tok.type_word, tok.data};
    assign m_tuser = tok.kind;
    assign m_tlast = tok.last;

endmodule

// ----- tb/sv/tb_save_container_stream_parser.sv -----
`timescale 1ns / 100ps

module tb_save_container_stream_parser;
    import scsp_pkg::*;

    typedef enum int {
        C_GOOD, C_SHORT, C_BADSIG, C_BADSUM, C_BADVER, C_BADTYPE, C_TRUNC, C_FLIP, C_TRAIL,
        C_EMPTY
    } shape_t;

    localparam int WD_LIMIT = 5000;
    localparam int HOLD_LEN = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    save_container_stream_parser u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    // parser copy
    logic [7:0]  c_xor;
    logic [31:0] c_ver, c_bool, c_num, c_str;
    phase_t      ph;
    logic [3:0]  hpos;
    logic [31:0] ssum, hash, wacc, left, ecnt, sleft, ctype;
    logic [2:0]  wcnt, ferr;
    logic [7:0]  sig [8] = '{8'h46, 8'h4C, 8'h58, 8'h53, 8'h41, 8'h56, 8'h45, 8'h31};

    token_t      tok_q [$];
    logic [8:0]  byte_q [$];
    logic [7:0]  pl [$];
    bit          offered = 0;
    int          send_idle = 0, recv_idle = 0;
    bit          hold_start = 0;
    int          hold_cnt = 0;
    int          errors = 0, n_bytes = 0, n_tokens = 0, n_files = 0, wd = 0;

    function automatic void clear_file();
        ph = PH_HDR; hpos = 0; ssum = 0; hash = FNV_BASIS; wacc = 0; wcnt = 0;
        left = 0; ecnt = 0; sleft = 0; ctype = 0; ferr = ST_OK;
    endfunction

    function automatic bit take_word(input logic [7:0] d);
        wacc = wacc | ({24'd0, d} << (8 * wcnt[1:0]));
        wcnt = wcnt + 3'd1;
        return wcnt == 3'd4;
    endfunction

    function automatic logic [31:0] grab();
        logic [31:0] w;
        w = wacc; wacc = 0; wcnt = 0;
        return w;
    endfunction

    function automatic void push_tok(input logic [1:0] k, input logic [7:0] b,
                                     input logic [31:0] t, input logic [31:0] n,
                                     input logic bv, input logic [2:0] st, input logic l);
        token_t x;
        x.kind = k; x.data = b; x.type_word = t; x.number = n;
        x.bool_bit = bv; x.status = st; x.last = l;
        tok_q.insert(tok_q.size(), x);
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  d;
        logic [31:0] w, etype, enum_w;
        logic        ended, ebool;
        logic [2:0]  st;
        ended = 0; etype = 0; enum_w = 0; ebool = 0;
        if (ph == PH_HDR) begin
            if (hpos < 8) begin
                if (b != sig[hpos[2:0]] && ferr == ST_OK) ferr = ST_SIGNATURE;
            end else if (hpos < 12) begin
                ssum = ssum | ({24'd0, b} << (8 * (hpos - 8)));
            end
            hpos = hpos + 4'd1;
            if (hpos >= 12) ph = (ferr == ST_SIGNATURE) ? PH_STOP : PH_VER;
        end else begin
            d = b ^ c_xor;
            hash = (hash ^ {24'd0, b}) * 32'd16777619;
            case (ph)
                PH_VER: if (take_word(d)) begin
                    w = grab();
                    if (w != c_ver) begin
                        if (ferr == ST_OK) ferr = ST_VERSION;
                        ph = PH_STOP;
                    end else ph = PH_CNT;
                end
                PH_CNT: if (take_word(d)) begin
                    w = grab(); left = w;
                    ph = (w == 0) ? PH_DONE : PH_KLEN;
                end
                PH_KLEN: if (take_word(d)) begin
                    w = grab(); sleft = w;
                    ph = (w == 0) ? PH_TYPE : PH_KEY;
                end
                PH_KEY: begin
                    push_tok(KIND_KEY, d, 0, ecnt, 0, ST_OK, 0);
                    sleft = sleft - 1;
                    if (sleft == 0) ph = PH_TYPE;
                end
                PH_TYPE: if (take_word(d)) begin
                    w = grab(); ctype = w;
                    if (w == c_bool) ph = PH_BOOL;
                    else if (w == c_num) begin ph = PH_NUM; sleft = 8; end
                    else if (w == c_str) ph = PH_SLEN;
                    else begin
                        if (ferr == ST_OK) ferr = ST_TYPE;
                        ph = PH_STOP;
                    end
                end
                PH_BOOL: if (take_word(d)) begin
                    w = grab(); ended = 1; ebool = (w != 0);
                end
                PH_NUM, PH_STR: begin
                    push_tok(KIND_VALUE, d, 0, ecnt, 0, ST_OK, 0);
                    sleft = sleft - 1;
                    if (sleft == 0) ended = 1;
                end
                PH_SLEN: if (take_word(d)) begin
                    w = grab(); sleft = w;
                    if (w == 0) ended = 1; else ph = PH_STR;
                end
                default: ;
            endcase
            if (ended) begin
                etype = ctype; enum_w = ecnt;
                ecnt = ecnt + 1; left = left - 1;
                ph = (left == 0) ? PH_DONE : PH_KLEN;
                if (!fin) push_tok(KIND_ENTRY, 0, etype, enum_w, ebool, ST_OK, 0);
            end
        end
        if (fin) begin
            if (hpos < 12) st = ST_SHORT;
            else if (ferr == ST_SIGNATURE) st = ST_SIGNATURE;
            else if (hash != ssum) st = ST_CHECKSUM;
            else if (ferr != ST_OK) st = ferr;
            else begin
                case (ph)
                    PH_VER, PH_CNT: st = ST_VERSION;
                    PH_KLEN, PH_KEY, PH_TYPE: st = ST_ENTRY;
                    PH_BOOL, PH_NUM, PH_SLEN, PH_STR: st = ST_VALUE;
                    default: st = ST_OK;
                endcase
            end
            push_tok(KIND_FILE, 0, ended ? etype : 32'd0, ecnt, ended ? ebool : 1'b0, st, 1);
            clear_file();
        end
    endfunction

    // sender
    always @(negedge clk) begin
        if (rst_n && !offered) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                {s_tlast, s_tdata} <= byte_q.pop_front();
                s_tvalid <= 1'b1;
                offered = 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk) begin
        if (hold_start) begin
            hold_cnt <= HOLD_LEN;
            hold_start = 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
        m_tready <= rst_n && (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin
        token_t got, want;
        if (s_tvalid && s_tready) begin
            predict_byte(s_tdata, s_tlast);
            offered = 0;
            n_bytes++;
        end
        if (m_tvalid && m_tready) begin
            got.kind = m_tuser; got.data = m_tdata[7:0]; got.type_word = m_tdata[39:8];
            got.number = m_tdata[71:40]; got.bool_bit = m_tdata[72];
            got.status = m_tdata[75:73]; got.last = m_tlast;
            n_tokens++;
            if (got.last) n_files++;
            if (tok_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item %p", got);
            end else begin
                want = tok_q.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wd = 0;
        else if (rst_n) wd++;
        if (wd >= WD_LIMIT) begin
            $display("timeout");
            $display("FAIL save_container_stream_parser");
            $finish;
        end
    end

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) pl.insert(pl.size(), w[8 * i +: 8]);
    endtask

    task automatic send_container(input shape_t shape);
        logic [7:0]  raw [$];
        logic [31:0] h, w, t;
        int          n, cut, k;
        pl.delete();
        put_word((shape == C_BADVER) ? c_ver ^ (32'd1 << $urandom_range(31)) : c_ver);
        n = (shape == C_EMPTY) ? 0 : $urandom_range(3);
        if (shape == C_BADTYPE && n == 0) n = 1;
        put_word(32'(n));
        for (int e = 0; e < n; e++) begin
            k = $urandom_range(4);
            put_word(32'(k));
            repeat (k) pl.insert(pl.size(), 8'($urandom));
            case ($urandom_range(2))
                0: t = c_bool;
                1: t = c_num;
                default: t = c_str;
            endcase
            if (shape == C_BADTYPE && e == n - 1) t = $urandom;
            put_word(t);
            if (t == c_bool) put_word($urandom_range(1) ? 32'd0 : $urandom);
            else if (t == c_num) repeat (8) pl.insert(pl.size(), 8'($urandom));
            else if (t == c_str) begin
                k = $urandom_range(5);
                put_word(32'(k));
                repeat (k) pl.insert(pl.size(), 8'($urandom));
            end
        end
        if (shape == C_TRAIL) repeat ($urandom_range(1, 3)) pl.insert(pl.size(), 8'($urandom));
        h = FNV_BASIS;
        foreach (pl[i]) begin
            raw.insert(raw.size(), pl[i] ^ c_xor);
            h = (h ^ {24'd0, pl[i] ^ c_xor}) * 32'd16777619;
        end
        if (shape == C_BADSUM) h = h ^ (32'd1 << $urandom_range(31));
        for (int i = 3; i >= 0; i--) raw.push_front(h[8 * i +: 8]);
        for (int i = 7; i >= 0; i--) raw.push_front(sig[i]);
        if (shape == C_BADSIG) raw[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);
        if (shape == C_FLIP) raw[$urandom_range(raw.size() - 1)] ^= 8'h01 << $urandom_range(7);
        if (shape == C_SHORT) begin
            cut = $urandom_range(1, 11);
            while (raw.size() > cut) void'(raw.pop_back());
        end
        if (shape == C_TRUNC) begin
            cut = $urandom_range(13, raw.size());
            while (raw.size() > cut) void'(raw.pop_back());
        end
        foreach (raw[i]) byte_q.insert(byte_q.size(), {(i == raw.size() - 1), raw[i]});
    endtask

    task automatic drain();
        wait (byte_q.size() == 0 && !offered && tok_q.size() == 0);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        @(negedge clk);
        cfg_wen <= 1'b1; cfg_index <= idx; cfg_data <= v;
        case (idx)
            REG_XOR_KEY: c_xor = v[7:0];
            REG_VERSION: c_ver = v;
            REG_BOOL:    c_bool = v;
            REG_NUMBER:  c_num = v;
            default:     c_str = v;
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] x, input logic [31:0] v, input logic [31:0] b,
                             input logic [31:0] nm, input logic [31:0] s);
        drain();
        write_reg(REG_XOR_KEY, {24'd0, x});
        write_reg(REG_VERSION, v);
        write_reg(REG_BOOL, b);
        write_reg(REG_NUMBER, nm);
        write_reg(REG_STRING, s);
    endtask

    task automatic random_part(input int bytes);
        int target;
        target = n_bytes + byte_q.size() + bytes;
        while (n_bytes + byte_q.size() < target) begin
            if ($urandom_range(99) < 70) send_container(C_GOOD);
            else send_container(shape_t'($urandom_range(C_SHORT, C_EMPTY)));
            wait (byte_q.size() < 40);
        end
    endtask

    initial begin
        c_xor = 8'h5A; c_ver = 1; c_bool = 0; c_num = 1; c_str = 2;
        clear_file();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_container(C_EMPTY);
        send_container(C_GOOD);
        byte_q.insert(byte_q.size(), {1'b1, 8'h46});
        send_container(C_SHORT);
        send_container(C_BADSIG);
        send_container(C_BADSUM);
        send_container(C_BADVER);
        send_container(C_BADTYPE);
        send_container(C_TRUNC);
        send_container(C_TRAIL);
        send_container(C_FLIP);

        send_idle = 30; recv_idle = 80;
        random_part(200);
        configure(8'h00, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        random_part(250);
        send_idle = 80; recv_idle = 30;
        configure(8'hFF, 32'hFFFF_FFFF, 32'h7, 32'h7, 32'h7);
        random_part(200);
        configure(8'hA5, 32'h1234_5678, 32'h10, 32'h20, 32'h20);
        random_part(200);
        send_idle = 0; recv_idle = 0;
        configure(8'h5A, 32'd1, 32'd0, 32'd1, 32'd2);
        hold_start = 1;
        random_part(200);
        configure(8'h3C, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD);
        random_part(200);

        wait (byte_q.size() == 0 && !offered && tok_q.size() == 0);
        repeat (20) @(posedge clk);
        if (tok_q.size() != 0) errors++;
        $display("covered %0d bytes in %0d containers, %0d tokens, six register settings",
                 n_bytes, n_files, n_tokens);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("PASS save_container_stream_parser");
        else
            $display("FAIL save_container_stream_parser");
        $finish;
    end

endmodule

// ----- save_container_stream_parser.f -----
design/scsp_pkg.sv
design/scsp_parser.sv
design/scsp_out_fifo.sv
design/save_container_stream_parser.sv
tb/sv/tb_save_container_stream_parser.sv
